// ===== rtl/text_char_decoder_core_defines.svh =====
// ----------------------------------------------------------------------------
// Text character decoder assertion macros
// Shared property forms for the decoder checks. The checks exist in
// simulation only; synthesis builds see empty macro bodies.
// ----------------------------------------------------------------------------
`ifndef TEXT_CHAR_DECODER_CORE_DEFINES_SVH
`define TEXT_CHAR_DECODER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TCD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TCD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define TCD_ASSERT_IMP(label, ante, cons, msg)
`define TCD_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/tcd_pkg.sv =====
// ----------------------------------------------------------------------------
// Text character decoder package
// Register indexes, mode codes and the run descriptor passed from the
// front end through the queue to the back end.
// ----------------------------------------------------------------------------
package tcd_pkg;

	// Configuration register indexes.
	localparam logic [1:0] REG_ENCODING_MODE = 2'd0;
	localparam logic [1:0] REG_BYTE_ORDER    = 2'd1;

	// Encoding mode codes. The unused code decodes as raw bytes.
	typedef logic [1:0] mode_t;
	localparam mode_t MODE_RAW   = 2'd0;
	localparam mode_t MODE_UTF8  = 2'd1;
	localparam mode_t MODE_UTF16 = 2'd2;

	// Default depth of the run queue between front and back end.
	localparam int TCD_QUEUE_DEPTH = 4;

	// One result of a run: error flag and number of text bytes covered.
	typedef struct packed {
		logic       invalid;
		logic [2:0] used;
	} tcd_slot_t;

	// All results caused by one input byte. At most one of them is a valid
	// character, and that one carries the code point.
	typedef struct packed {
		logic [2:0]           count;
		tcd_slot_t [3:0]      slots;
		logic [20:0]          cp;
	} tcd_run_t;

	// Queue to back end handshake.
	typedef struct packed {
		logic avail;
		logic pop;
	} tcd_qctl_t;

endpackage

// ===== rtl/tcd_front.sv =====
// ----------------------------------------------------------------------------
// Text character decoder front end
// Holds configuration and decoding state, takes one byte per cycle while the
// queue is not full and turns it into a run descriptor for the back end.
// ----------------------------------------------------------------------------
module tcd_front import tcd_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  logic [1:0]     wr_index,
	input  logic [1:0]     wr_data,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     in_byte,
	input  logic           end_of_text,
	input  logic           queue_full,
	output logic           push,
	output tcd_run_t       run
);

	localparam tcd_slot_t SLOT_ERR1 = '{invalid: 1'b1, used: 3'd1};
	localparam tcd_slot_t SLOT_ERR2 = '{invalid: 1'b1, used: 3'd2};

	mode_t       mode_q;
	logic        order_q;
	logic [20:0] acc_q, acc_d;
	logic [2:0]  exp_q, exp_d;
	logic [2:0]  seen_q, seen_d;
	logic [7:0]  held_q, held_d;
	logic        phase_q, phase_d;
	logic [9:0]  hs_q, hs_d;
	logic        sp_q, sp_d;
	logic        accept;
	logic        cfg_hit;

	assign in_stall = queue_full;
	assign accept   = in_valid && !in_stall;
	assign cfg_hit  = wr_en && (wr_index == REG_ENCODING_MODE || wr_index == REG_BYTE_ORDER);
	assign push     = accept && (run.count != 3'd0);

	always_comb begin
		logic [2:0]  cnt;
		logic [2:0]  seen_inc;
		logic [20:0] acc_shift;
		logic [15:0] word;
		logic        is_low;
		logic        is_high;
		logic        paired;
		cnt       = 3'd0;
		run       = '0;
		acc_d     = acc_q;
		exp_d     = exp_q;
		seen_d    = seen_q;
		held_d    = held_q;
		phase_d   = phase_q;
		hs_d      = hs_q;
		sp_d      = sp_q;
		seen_inc  = seen_q + 3'd1;
		acc_shift = {acc_q[14:0], in_byte[5:0]};
		word      = '0;
		is_low    = 1'b0;
		is_high   = 1'b0;
		paired    = 1'b0;
		unique case (mode_q)
			MODE_UTF8: begin
				if (exp_q != 3'd0 && in_byte[7:6] == 2'b10) begin
					if (seen_inc >= exp_q) begin
						run.slots[cnt[1:0]] = '{invalid: 1'b0, used: exp_q};
						run.cp = acc_shift;
						cnt    = cnt + 3'd1;
						acc_d  = '0;
						exp_d  = '0;
						seen_d = '0;
					end else begin
						acc_d  = acc_shift;
						seen_d = seen_inc;
					end
				end else begin
					// A broken sequence reports each byte it had taken.
					for (int i = 0; i < 3; i++) begin
						if (3'(i) < seen_q) begin
							run.slots[cnt[1:0]] = SLOT_ERR1;
							cnt = cnt + 3'd1;
						end
					end
					acc_d  = '0;
					exp_d  = '0;
					seen_d = '0;
					if (!in_byte[7]) begin
						run.slots[cnt[1:0]] = '{invalid: 1'b0, used: 3'd1};
						run.cp = {13'd0, in_byte};
						cnt    = cnt + 3'd1;
					end else if (in_byte[7:5] == 3'b110) begin
						if (in_byte[4:1] == 4'd0) begin
							run.slots[cnt[1:0]] = SLOT_ERR1;
							cnt = cnt + 3'd1;
						end else begin
							acc_d  = {16'd0, in_byte[4:0]};
							exp_d  = 3'd2;
							seen_d = 3'd1;
						end
					end else if (in_byte[7:4] == 4'b1110) begin
						acc_d  = {17'd0, in_byte[3:0]};
						exp_d  = 3'd3;
						seen_d = 3'd1;
					end else if (in_byte[7:3] == 5'b11110) begin
						acc_d  = {18'd0, in_byte[2:0]};
						exp_d  = 3'd4;
						seen_d = 3'd1;
					end else begin
						run.slots[cnt[1:0]] = SLOT_ERR1;
						cnt = cnt + 3'd1;
					end
				end
				if (end_of_text) begin
					for (int i = 0; i < 3; i++) begin
						if (3'(i) < seen_d) begin
							run.slots[cnt[1:0]] = SLOT_ERR1;
							cnt = cnt + 3'd1;
						end
					end
					acc_d  = '0;
					exp_d  = '0;
					seen_d = '0;
				end
			end
			MODE_UTF16: begin
				if (!phase_q) begin
					held_d  = in_byte;
					phase_d = 1'b1;
				end else begin
					word    = order_q ? {held_q, in_byte} : {in_byte, held_q};
					is_low  = (word[15:10] == 6'b110111);
					is_high = (word[15:10] == 6'b110110);
					phase_d = 1'b0;
					held_d  = '0;
					if (sp_q) begin
						sp_d = 1'b0;
						hs_d = '0;
						if (is_low) begin
							run.slots[cnt[1:0]] = '{invalid: 1'b0, used: 3'd4};
							run.cp = {1'b0, hs_q, word[9:0]} + 21'h10000;
							cnt    = cnt + 3'd1;
							paired = 1'b1;
						end else begin
							run.slots[cnt[1:0]] = SLOT_ERR2;
							cnt = cnt + 3'd1;
						end
					end
					if (!paired) begin
						if (word[15:11] != 5'b11011) begin
							run.slots[cnt[1:0]] = '{invalid: 1'b0, used: 3'd2};
							run.cp = {5'd0, word};
							cnt    = cnt + 3'd1;
						end else if (is_high) begin
							hs_d = word[9:0];
							sp_d = 1'b1;
						end else begin
							run.slots[cnt[1:0]] = SLOT_ERR2;
							cnt = cnt + 3'd1;
						end
					end
				end
				if (end_of_text) begin
					if (sp_d) begin
						run.slots[cnt[1:0]] = SLOT_ERR2;
						cnt = cnt + 3'd1;
					end
					if (phase_d) begin
						run.slots[cnt[1:0]] = SLOT_ERR1;
						cnt = cnt + 3'd1;
					end
					acc_d   = '0;
					exp_d   = '0;
					seen_d  = '0;
					held_d  = '0;
					phase_d = 1'b0;
					hs_d    = '0;
					sp_d    = 1'b0;
				end
			end
			default: begin
				run.slots[cnt[1:0]] = '{invalid: 1'b0, used: 3'd1};
				run.cp = {13'd0, in_byte};
				cnt    = cnt + 3'd1;
			end
		endcase
		run.count = cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_RAW;
			order_q <= 1'b0;
			acc_q   <= '0;
			exp_q   <= '0;
			seen_q  <= '0;
			held_q  <= '0;
			phase_q <= 1'b0;
			hs_q    <= '0;
			sp_q    <= 1'b0;
		end else if (cfg_hit) begin
			if (wr_index == REG_ENCODING_MODE) begin
				mode_q <= wr_data;
			end else begin
				order_q <= wr_data[0];
			end
			acc_q   <= '0;
			exp_q   <= '0;
			seen_q  <= '0;
			held_q  <= '0;
			phase_q <= 1'b0;
			hs_q    <= '0;
			sp_q    <= 1'b0;
		end else if (accept) begin
			acc_q   <= acc_d;
			exp_q   <= exp_d;
			seen_q  <= seen_d;
			held_q  <= held_d;
			phase_q <= phase_d;
			hs_q    <= hs_d;
			sp_q    <= sp_d;
		end
	end

endmodule

// ===== rtl/tcd_queue.sv =====
// ----------------------------------------------------------------------------
// Text character decoder run queue
// Small register queue of run descriptors between front and back end.
// ----------------------------------------------------------------------------
module tcd_queue import tcd_pkg::*; #(
	parameter int DEPTH = TCD_QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  tcd_run_t  push_run,
	output logic      full,
	input  tcd_qctl_t ctl_in,
	output logic      avail,
	output tcd_run_t  head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tcd_run_t          mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              pop;

	assign full  = (count_q == CW'(DEPTH));
	assign avail = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];
	assign pop   = ctl_in.pop && ctl_in.avail;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/tcd_back.sv =====
// ----------------------------------------------------------------------------
// Text character decoder back end
// Walks through the results of the run at the head of the queue and
// presents them one per cycle on the output channel while it is not stalled.
// ----------------------------------------------------------------------------
module tcd_back import tcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        avail,
	input  tcd_run_t    head,
	output tcd_qctl_t   ctl,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [20:0] code_point,
	output logic        invalid,
	output logic [2:0]  bytes_used,
	output logic        last_of_run
);

	logic [1:0] idx_q;
	tcd_slot_t  slot;
	logic       take;

	assign slot        = head.slots[idx_q];
	assign out_valid   = avail;
	assign code_point  = slot.invalid ? '0 : head.cp;
	assign invalid     = slot.invalid;
	assign bytes_used  = slot.used;
	assign last_of_run = ({1'b0, idx_q} == head.count - 3'd1);
	assign take        = out_valid && !out_stall;
	assign ctl.avail   = avail;
	assign ctl.pop     = take && last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (take) begin
			idx_q <= last_of_run ? '0 : idx_q + 2'd1;
		end
	end

endmodule

// ===== rtl/text_char_decoder_core.sv =====
// ----------------------------------------------------------------------------
// Text character decoder core
// Decodes a byte stream as raw bytes, UTF-8 or UTF-16 into code points.
// ----------------------------------------------------------------------------
// The decoder takes one text byte per cycle while the queue is not full and
// returns one result per cycle while the output is not stalled. A byte can
// cause zero to four results: zero while it only extends a pending sequence,
// one for a finished character, and several when an interrupted sequence or
// the end of text is reported as errors. The run of a byte is registered in
// the queue before its first result appears on the output. A front end holds
// the decoding state and turns each byte into a run of results; a queue of
// QUEUE_DEPTH runs carries them to the back end, which hands them out. A byte
// that causes several results holds the output longer, which the queue
// absorbs until it is full. Writing a configuration register clears all
// decoding state; write only while no request is in flight.
// ----------------------------------------------------------------------------
`include "text_char_decoder_core_defines.svh"

module text_char_decoder_core import tcd_pkg::*; #(
	parameter int QUEUE_DEPTH = TCD_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [1:0]  wr_data,
	// Input channel: one text byte per request.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        end_of_text,
	// Output channel: one decoded result per request.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [20:0] code_point,
	output logic        invalid,
	output logic [2:0]  bytes_used,
	output logic        last_of_run
);

	tcd_run_t  push_run;
	tcd_run_t  head_run;
	logic      push;
	logic      queue_full;
	logic      queue_avail;
	tcd_qctl_t qctl;

	// The front end classifies each byte and updates the decoding state.
	tcd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.queue_full  (queue_full),
		.push        (push),
		.run         (push_run)
	);

	// Runs wait here so that either side can stall on its own.
	tcd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_run (push_run),
		.full     (queue_full),
		.ctl_in   (qctl),
		.avail    (queue_avail),
		.head     (head_run)
	);

	// The back end expands a run into single results.
	tcd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.avail       (queue_avail),
		.head        (head_run),
		.ctl         (qctl),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.code_point  (code_point),
		.invalid     (invalid),
		.bytes_used  (bytes_used),
		.last_of_run (last_of_run)
	);

	// An error result never carries a code point.
	`TCD_ASSERT_IMP(a_err_zero_cp, out_valid && invalid, code_point == 21'd0, "error result with nonzero code point")

	// Every result accounts for one to four text bytes.
	`TCD_ASSERT_IMP(a_used_range, out_valid, bytes_used != 3'd0 && bytes_used <= 3'd4, "bytes_used out of range")

	// A run that is not finished keeps the output channel busy.
	`TCD_ASSERT_NXT(a_run_continues, out_valid && !out_stall && !last_of_run, out_valid, "run cut short")

endmodule
